@@ rtl/fdtm_pkg.sv @@
// ----------------------------------------------------------------------------
// fdtm_pkg
// Shared types and constants for the fragment depth / transparency merge unit.
// ----------------------------------------------------------------------------
package fdtm_pkg;

  localparam int unsigned PixelsDef = 65536;
  localparam int unsigned LayersDef = 4;

  localparam logic [31:0] DepthEmpty   = 32'hFFFF_FFFF;
  localparam logic [31:0] DepthMax     = 32'hFFFF_FFFE;
  localparam logic [31:0] NearLimitRst = 32'd66;
  localparam logic [7:0]  AlphaOpaque  = 8'd255;
  localparam int unsigned IdxBits      = 16;

  typedef enum logic [1:0] {
    MODE_MERGE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_READX = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OUT_CLIPPED  = 3'd0,
    OUT_HIDDEN   = 3'd1,
    OUT_BASE     = 3'd2,
    OUT_INSERTED = 3'd3,
    OUT_DROPPED  = 3'd4,
    OUT_CLEARED  = 3'd5,
    OUT_READ     = 3'd6,
    OUT_UNUSED   = 3'd7
  } outcome_e;

  typedef enum logic {
    CFG_TRANSPARENCY = 1'b0,
    CFG_NEAR_LIMIT   = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pixel_index;
    logic [31:0] depth;
    logic [31:0] color;
    logic [2:0]  layer_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] read_depth;
    logic [31:0] read_color;
  } out_item_t;

  typedef struct packed {
    logic [31:0] depth;
    logic [31:0] color;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_in;
    logic rd_reg;
    logic mod_step;
    logic exe;
    logic clr_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
  } status_t;

endpackage

@@ rtl/fdtm_ram.sv @@
// ----------------------------------------------------------------------------
// fdtm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fdtm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fdtm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fdtm_ctrl
// Sequencer: clearing pass, index reduction, pixel read and update.
// ----------------------------------------------------------------------------
module fdtm_ctrl #(
  parameter int unsigned Pixels = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fdtm_pkg::cmd_t      cmd_o,
  input  fdtm_pkg::status_t   status_i
);
  import fdtm_pkg::*;

  localparam bit NeedMod = (Pixels < 65536) && ((Pixels & (Pixels - 1)) != 0);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_EXE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load_in  = accept;
    cmd_o.rd_in    = accept && !NeedMod;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = NeedMod ? ST_MOD : ST_EXE;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_done) state_d = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd_reg = 1'b1;
        state_d      = ST_EXE;
      end
      ST_EXE: begin
        cmd_o.exe = slot_free;
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.exe) out_valid_d = 1'b1;
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exe |-> !(out_valid_q && out_stall_i))
    else $error("result slot overwritten");

  // an update always leaves a result to deliver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exe |=> out_valid_o)
    else $error("update without result");

  // nothing is accepted during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.clr_step) |-> !cmd_o.load_in)
    else $error("transaction accepted while clearing");

  // a read is followed by the update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_in || cmd_o.rd_reg) |=> (state_q == ST_EXE))
    else $error("read not followed by update");

endmodule

@@ rtl/fdtm_dpath.sv @@
// ----------------------------------------------------------------------------
// fdtm_dpath
// Pixel word storage, configuration registers and the merge logic.
// ----------------------------------------------------------------------------
module fdtm_dpath #(
  parameter int unsigned Pixels = 65536,
  parameter int unsigned Layers = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdtm_pkg::in_item_t   in_data_i,
  output fdtm_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  fdtm_pkg::cmd_t       cmd_i,
  output fdtm_pkg::status_t    status_o
);
  import fdtm_pkg::*;

  localparam int unsigned Aw     = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam int unsigned Pw     = $clog2(Layers + 1);
  localparam int unsigned WordW  = 64 * (Layers + 1);
  localparam bit          NeedMod = (Pixels < 65536) && ((Pixels & (Pixels - 1)) != 0);
  localparam bit          Wide    = (Pixels >= 65536);
  // reciprocal of the pixel count in 0.32 fixed point, rounded up
  localparam logic [31:0] Recip   = 32'((64'd1 << 32) / 64'(Pixels) + 64'd1);

  typedef entry_t [Layers:0] word_t;

  // configuration
  logic        te_q;
  logic [31:0] near_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q   <= 1'b0;
      near_q <= NearLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_TRANSPARENCY: te_q   <= cfg_data_i[0];
        CFG_NEAR_LIMIT:   near_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pixel address from index
  function automatic logic [Aw-1:0] map_idx(input logic [15:0] idx);
    logic [31:0] m;
    m = 32'(idx) & 32'(Pixels - 1);
    if (Wide) return Aw'(idx);
    return m[Aw-1:0];
  endfunction

  // latched transaction
  logic [1:0]    mode_q;
  logic [31:0]   z_q, c_q;
  logic [2:0]    sel_q;
  logic [Aw-1:0] addr_q;
  logic [15:0]   rem_q;
  logic          step_q;
  logic [Aw-1:0] in_addr;

  assign in_addr = map_idx(in_data_i.pixel_index);

  // index reduction: quotient by reciprocal, then remainder by back-multiply
  logic [15:0] quo_q;
  logic [47:0] quo_prod;
  logic [31:0] quo_back;
  logic [15:0] rem_red;
  assign quo_prod = 48'(rem_q) * 48'(Recip);
  assign quo_back = 32'(quo_q) * 32'(Pixels);
  assign rem_red  = rem_q - quo_back[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= in_data_i.mode;
      z_q    <= (in_data_i.depth == DepthEmpty) ? DepthMax : in_data_i.depth;
      c_q    <= in_data_i.color;
      sel_q  <= in_data_i.layer_select;
      addr_q <= in_addr;
      rem_q  <= in_data_i.pixel_index;
    end else if (cmd_i.mod_step) begin
      if (NeedMod && step_q) addr_q <= Aw'(rem_red);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      step_q <= 1'b0;
    end else if (cmd_i.mod_step) begin
      step_q <= !step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_step && !step_q) quo_q <= quo_prod[47:32];
  end

  assign status_o.mod_done = step_q;

  // clearing sweep
  logic [Aw-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + Aw'(1);
    end
  end
  assign status_o.clr_done = (clr_q == Aw'(Pixels - 1));

  // storage
  word_t         old_w, new_w, empty_w;
  logic [WordW-1:0] rdata;
  logic          wr_en;
  logic          ram_we;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata;

  always_comb begin
    for (int i = 0; i <= Layers; i++) begin
      empty_w[i].depth = DepthEmpty;
      empty_w[i].color = '0;
    end
  end

  assign ram_we    = cmd_i.clr_step || (cmd_i.exe && wr_en);
  assign ram_waddr = cmd_i.clr_step ? clr_q : addr_q;
  assign ram_wdata = cmd_i.clr_step ? empty_w : new_w;
  assign ram_raddr = cmd_i.rd_in ? in_addr : addr_q;
  assign old_w     = rdata;

  fdtm_ram #(
    .Width (WordW),
    .Depth (Pixels)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_in || cmd_i.rd_reg),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // merge decision
  logic [Layers-1:0] hit;
  logic [Pw-1:0]     pos;
  logic              full, opaque;
  out_item_t         res;
  logic [Pw:0]       j;

  always_comb begin
    for (int i = 0; i < Layers; i++) begin
      hit[i] = (old_w[i+1].depth == DepthEmpty) || (old_w[i+1].depth < z_q);
    end
    pos = Pw'(Layers);
    for (int i = Layers - 1; i >= 0; i--) begin
      if (hit[i]) pos = Pw'(i);
    end
    full   = (old_w[Layers].depth != DepthEmpty);
    opaque = (c_q[31:24] == AlphaOpaque);

    new_w          = old_w;
    wr_en          = 1'b0;
    res.outcome    = OUT_READ;
    res.read_depth = '0;
    res.read_color = '0;
    j              = '0;

    case (mode_e'(mode_q))
      MODE_MERGE: begin
        if (z_q <= near_q) begin
          res.outcome = OUT_CLIPPED;
        end else if (z_q >= old_w[0].depth) begin
          res.outcome = OUT_HIDDEN;
        end else if (!te_q || opaque) begin
          res.outcome    = OUT_BASE;
          wr_en          = 1'b1;
          new_w[0].depth = z_q;
          new_w[0].color = c_q;
          if (te_q) begin
            // drop layers behind the fragment and compact
            for (int i = 0; i < Layers; i++) begin
              j = (Pw+1)'(i) + (Pw+1)'(pos);
              if (j < (Pw+1)'(Layers)) new_w[i+1] = old_w[j[Pw-1:0] + Pw'(1)];
              else                      new_w[i+1] = empty_w[0];
            end
          end
        end else if (full) begin
          if (pos == '0) begin
            res.outcome = OUT_DROPPED;
          end else begin
            res.outcome = OUT_INSERTED;
            wr_en       = 1'b1;
            // farthest layer falls out, fragment sits below pos
            for (int i = 0; i < Layers; i++) begin
              if (Pw'(i) + Pw'(1) < pos) begin
                new_w[i+1] = old_w[i+2];
              end else if (Pw'(i) + Pw'(1) == pos) begin
                new_w[i+1].depth = z_q;
                new_w[i+1].color = c_q;
              end
            end
          end
        end else begin
          res.outcome = OUT_INSERTED;
          wr_en       = 1'b1;
          // open a slot at pos, nearer layers move up
          for (int i = 0; i < Layers; i++) begin
            if (Pw'(i) == pos) begin
              new_w[i+1].depth = z_q;
              new_w[i+1].color = c_q;
            end else if (Pw'(i) > pos) begin
              new_w[i+1] = old_w[i];
            end
          end
        end
      end
      MODE_CLEAR: begin
        res.outcome = OUT_CLEARED;
        wr_en       = 1'b1;
        new_w       = empty_w;
      end
      default: begin
        res.outcome = OUT_READ;
        if (32'(sel_q) <= Layers) begin
          res.read_depth = old_w[sel_q].depth;
          res.read_color = old_w[sel_q].color;
        end else begin
          res.read_depth = DepthEmpty;
        end
      end
    endcase
  end

  // result register
  out_item_t out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.exe) out_q <= res;
  end
  assign out_data_o = out_q;

endmodule

@@ rtl/fragment_depth_transparency_merge.sv @@
// ----------------------------------------------------------------------------
// fragment_depth_transparency_merge
// Per-pixel depth test and merge with a sorted list of translucent layers.
// ----------------------------------------------------------------------------
// Without index reduction, the accept cycle reads the pixel's whole word
// (base plus all layers) from one RAM port, and the update state then tests,
// merges and writes it back once the result slot is free; one transaction is in
// flight at a time, set by that read-modify-write of the pixel word. When PIXELS
// is not a power of two and below 65536, an index reduction and a read state
// come before the update. After reset a clearing pass empties every pixel,
// during which input is stalled; configuration writes are taken at any time.
module fragment_depth_transparency_merge #(
  parameter int unsigned PIXELS = fdtm_pkg::PixelsDef,
  parameter int unsigned LAYERS = fdtm_pkg::LayersDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fdtm_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fdtm_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import fdtm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  fdtm_ctrl #(
    .Pixels (PIXELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // storage and merge
  fdtm_dpath #(
    .Pixels (PIXELS),
    .Layers (LAYERS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ sim/fdtm_checker.sv @@
// ----------------------------------------------------------------------------
// fdtm_checker
// Watches the fragment, result and register channels of the merge unit,
// keeps its own copy of every pixel touched so far and checks each result
// transaction against the predicted outcome and read-back entry.
// ----------------------------------------------------------------------------
module fdtm_checker (
  input  logic                clk_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  fdtm_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  fdtm_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);
  import fdtm_pkg::*;

  localparam int unsigned NumLayers = LayersDef;

  // sparse pixel store, missing keys mean the reset contents
  logic [31:0] base_z_mem [int];
  logic [31:0] base_c_mem [int];
  logic [31:0] lay_z_mem  [int];
  logic [31:0] lay_c_mem  [int];

  logic        transp_en;
  logic [31:0] near_lim;
  out_item_t   result_q [$];

  function automatic logic [31:0] fetch(ref logic [31:0] mem [int], input int key,
                                        input logic [31:0] dflt);
    if (mem.exists(key)) return mem[key];
    return dflt;
  endfunction

  // apply one fragment transaction to the pixel copy and give its result
  function automatic out_item_t merge_pixel(input in_item_t it);
    out_item_t   res;
    int          p;
    int          pos;
    int          i;
    logic [31:0] z;
    logic [31:0] bz, bc, cz, cc, t;
    logic [31:0] lz [NumLayers];
    logic [31:0] lc [NumLayers];
    p = int'(it.pixel_index) % PixelsDef;
    z = (it.depth > DepthMax) ? DepthMax : it.depth;
    bz = fetch(base_z_mem, p, DepthEmpty);
    bc = fetch(base_c_mem, p, 32'd0);
    for (i = 0; i < NumLayers; i++) begin
      lz[i] = fetch(lay_z_mem, p * NumLayers + i, DepthEmpty);
      lc[i] = fetch(lay_c_mem, p * NumLayers + i, 32'd0);
    end
    res = '0;
    case (it.mode)
      MODE_MERGE: begin
        if (z <= near_lim) begin
          res.outcome = OUT_CLIPPED;
        end else if (z >= bz) begin
          res.outcome = OUT_HIDDEN;
        end else if (!transp_en) begin
          bz = z;
          bc = it.color;
          res.outcome = OUT_BASE;
        end else begin
          pos = NumLayers;
          for (i = NumLayers - 1; i >= 0; i--) begin
            if (lz[i] == DepthEmpty || lz[i] < z) pos = i;
          end
          if (it.color[31:24] == AlphaOpaque) begin
            // opaque: layers behind it go away, the rest compacts down
            bz = z;
            bc = it.color;
            for (i = 0; i < NumLayers; i++) begin
              if (i + pos < NumLayers) begin
                lz[i] = lz[i + pos];
                lc[i] = lc[i + pos];
              end else begin
                lz[i] = DepthEmpty;
                lc[i] = 32'd0;
              end
            end
            res.outcome = OUT_BASE;
          end else if (lz[NumLayers - 1] != DepthEmpty) begin
            // full list: farthest layer falls out
            if (pos == 0) begin
              res.outcome = OUT_DROPPED;
            end else begin
              cz = z;
              cc = it.color;
              for (i = pos - 1; i >= 0; i--) begin
                t = lz[i]; lz[i] = cz; cz = t;
                t = lc[i]; lc[i] = cc; cc = t;
              end
              res.outcome = OUT_INSERTED;
            end
          end else begin
            cz = z;
            cc = it.color;
            for (i = pos; i < NumLayers; i++) begin
              if (cz != DepthEmpty) begin
                t = lz[i]; lz[i] = cz; cz = t;
                t = lc[i]; lc[i] = cc; cc = t;
              end
            end
            res.outcome = OUT_INSERTED;
          end
        end
      end
      MODE_CLEAR: begin
        bz = DepthEmpty;
        bc = 32'd0;
        for (i = 0; i < NumLayers; i++) begin
          lz[i] = DepthEmpty;
          lc[i] = 32'd0;
        end
        res.outcome = OUT_CLEARED;
      end
      default: begin
        res.outcome = OUT_READ;
        if (it.layer_select == 3'd0) begin
          res.read_depth = bz;
          res.read_color = bc;
        end else if (it.layer_select <= NumLayers) begin
          res.read_depth = lz[it.layer_select - 1];
          res.read_color = lc[it.layer_select - 1];
        end else begin
          res.read_depth = DepthEmpty;
          res.read_color = 32'd0;
        end
      end
    endcase
    base_z_mem[p] = bz;
    base_c_mem[p] = bc;
    for (i = 0; i < NumLayers; i++) begin
      lay_z_mem[p * NumLayers + i] = lz[i];
      lay_c_mem[p * NumLayers + i] = lc[i];
    end
    return res;
  endfunction

  initial begin
    transp_en = 1'b0;
    near_lim  = NearLimitRst;
    errors_o  = 0;
    pending_o = 0;
  end

  // register writes, fragment predictions, result comparison
  always @(posedge clk_i) begin
    out_item_t want;
    if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i == CFG_TRANSPARENCY) transp_en = cfg_data_i[0];
      else near_lim = cfg_data_i;
    end
    if (in_valid_i && !in_stall_i) result_q.push_back(merge_pixel(in_data_i));
    if (out_valid_i && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors_o++;
      end else begin
        want = result_q.pop_front();
        if (out_data_i.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, out_data_i.outcome);
          errors_o++;
        end
        if (out_data_i.read_depth !== want.read_depth) begin
          $error("read_depth: expected %h, got %h", want.read_depth,
                 out_data_i.read_depth);
          errors_o++;
        end
        if (out_data_i.read_color !== want.read_color) begin
          $error("read_color: expected %h, got %h", want.read_color,
                 out_data_i.read_color);
          errors_o++;
        end
      end
    end
    pending_o = result_q.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives fragment, clear and read transactions into the merge unit over a
// series of register settings, with random idling and stalls on both
// channels; the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import fdtm_pkg::*;

  localparam int WatchdogLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          pending;
  int          errors;
  int          hold_cycles;
  bit          quiet;
  logic [15:0] pix_pool [8];

  fragment_depth_transparency_merge DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fdtm_checker u_checker (
    .clk_i       (clk),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // receiver stalls: long hold on request, else random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 20);
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= WatchdogLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic send_fragment(input in_item_t it);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(input mode_e m, input logic [15:0] p,
                                         input logic [31:0] z, input logic [31:0] c,
                                         input logic [2:0] sel);
    in_item_t it;
    it.mode = m;
    it.pixel_index = p;
    it.depth = z;
    it.color = c;
    it.layer_select = sel;
    return it;
  endfunction

  // random transaction, mostly merges onto a few pixels so layers fill up
  function automatic in_item_t rand_item();
    in_item_t    it;
    int          r;
    logic [31:0] c;
    r = $urandom_range(99);
    it.pixel_index = ($urandom_range(19) == 0) ? 16'($urandom) : pix_pool[$urandom_range(7)];
    it.depth = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200000, 20);
    if ($urandom_range(49) == 0) it.depth = DepthEmpty;
    c = $urandom;
    if ($urandom_range(3) == 0) c[31:24] = AlphaOpaque;
    it.color = c;
    it.layer_select = 3'($urandom);
    if (r < 70) it.mode = MODE_MERGE;
    else if (r < 74) it.mode = MODE_CLEAR;
    else if (r < 96) it.mode = MODE_READ;
    else it.mode = MODE_READX;
    return it;
  endfunction

  task automatic read_back(input logic [15:0] p);
    for (int s = 0; s <= LayersDef; s++)
      send_fragment(make_item(MODE_READ, p, 32'd0, 32'd0, 3'(s)));
  endtask

  initial begin
    logic        ph_en   [6];
    logic [31:0] ph_near [6];
    int          ph_cnt  [6];
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_TRANSPARENCY;
    cfg_data    = '0;
    hold_cycles = 0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    for (int i = 0; i < 8; i++) pix_pool[i] = 16'($urandom);
    pix_pool[0] = 16'h0000;
    pix_pool[1] = 16'hFFFF;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset register values, extremes, all modes
    send_fragment(make_item(MODE_READ, 16'h0000, 32'd0, 32'd0, 3'd0));
    send_fragment(make_item(MODE_MERGE, 16'h0001, 32'd66, 32'h11223344, 3'd0));
    send_fragment(make_item(MODE_MERGE, 16'h0001, 32'd67, 32'h80112233, 3'd0));
    send_fragment(make_item(MODE_MERGE, 16'h0001, DepthEmpty, 32'h01020304, 3'd0));
    send_fragment(make_item(MODE_READ, 16'h0001, 32'd0, 32'd0, 3'd0));
    write_reg(CFG_TRANSPARENCY, 32'd1);
    send_fragment(make_item(MODE_MERGE, 16'hFFFF, DepthEmpty, 32'hFFFFFFFF, 3'd0));
    // translucent fills the list, then further fragments into the full list
    for (int i = 0; i < 5; i++)
      send_fragment(make_item(MODE_MERGE, 16'hFFFF, 32'd5000 - 32'(i) * 500,
                              32'h40000000 | 32'(i), 3'd0));
    send_fragment(make_item(MODE_MERGE, 16'hFFFF, 32'd9000, 32'h7F00AAAA, 3'd0));
    send_fragment(make_item(MODE_MERGE, 16'hFFFF, 32'd3300, 32'h7F00BBBB, 3'd0));
    read_back(16'hFFFF);
    send_fragment(make_item(MODE_READ, 16'hFFFF, 32'd0, 32'd0, 3'd7));
    send_fragment(make_item(MODE_READX, 16'hFFFF, 32'd0, 32'd0, 3'd2));
    // opaque in the middle discards the farther layers
    send_fragment(make_item(MODE_MERGE, 16'hFFFF, 32'd3100, 32'hFF123456, 3'd0));
    read_back(16'hFFFF);
    send_fragment(make_item(MODE_CLEAR, 16'hFFFF, 32'd0, 32'd0, 3'd0));
    write_reg(CFG_NEAR_LIMIT, 32'd0);
    send_fragment(make_item(MODE_MERGE, 16'h0002, 32'd0, 32'h00000001, 3'd0));
    send_fragment(make_item(MODE_MERGE, 16'h0002, 32'd1, 32'h00000001, 3'd0));

    // random phases over several register settings
    ph_en[0] = 1'b1; ph_near[0] = 32'd66;        ph_cnt[0] = 300;
    ph_en[1] = 1'b0; ph_near[1] = 32'd66;        ph_cnt[1] = 200;
    ph_en[2] = 1'b1; ph_near[2] = 32'd0;         ph_cnt[2] = 300;
    ph_en[3] = 1'b1; ph_near[3] = DepthMax;      ph_cnt[3] = 60;
    ph_en[4] = 1'b0; ph_near[4] = 32'd0;         ph_cnt[4] = 200;
    ph_en[5] = 1'b1; ph_near[5] = $urandom_range(5000); ph_cnt[5] = 370;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_TRANSPARENCY, {31'd0, ph_en[ph]});
      write_reg(CFG_NEAR_LIMIT, ph_near[ph]);
      for (int n = 0; n < ph_cnt[ph]; n++) begin
        if (ph == 0 && n == 50) hold_cycles = 400;
        if (ph == 2) quiet = (n >= 100 && n < 200);
        if (ph == 5 && n == 150) drain();
        send_fragment(rand_item());
      end
      quiet = 1'b0;
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
